@@ rtl/hpg_pkg.sv @@
// Shared types and constants of the core hotplug governor.
package hpg_pkg;

  localparam int MODE_W = 2;
  localparam int MASK_W = 4;
  localparam int CORE_W = 2;
  localparam int IVL_W  = 10;
  localparam int CNT_W  = 10;
  localparam int THR_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_SLOTS = 4;
  localparam int THR_SLOTS = 3;

  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DISP_OFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISP_ON  = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN3  = 3'd6;

  localparam logic signed [CNT_W-1:0] PLUG_VALUE = -10'sd60;
  localparam logic signed [CNT_W-1:0] CNT_MIN    = -10'sd512;
  localparam logic signed [CNT_W-1:0] CNT_MAX    = 10'sd511;

  localparam logic [THR_SLOTS-1:0][THR_W-1:0] UP_RESET   = {8'hD8, 8'hEF, 8'hFF};
  localparam logic [THR_SLOTS-1:0][THR_W-1:0] DOWN_RESET = {8'd40, 8'd100, 8'd170};

  typedef struct packed {
    logic                             enable;
    logic [THR_SLOTS-1:0][THR_W-1:0]  up_thr;   // two's complement
    logic [THR_SLOTS-1:0][THR_W-1:0]  down_thr;
  } cfg_t;

  typedef struct packed {
    logic                     touch;
    logic [1:0]               action;
    logic [CORE_W-1:0]        core;
    logic signed [CNT_W-1:0]  count;
  } dec_t;

endpackage

@@ rtl/hpg_req_if.sv @@
// Input item channel of the hotplug governor.
interface hpg_req_if;
  import hpg_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [MASK_W-1:0] online_mask;
  logic [MASK_W-1:0] freq_known_mask;
  logic [MASK_W-1:0] at_max_mask;
  logic [MASK_W-1:0] at_min_mask;

  modport source (output valid, mode, online_mask, freq_known_mask, at_max_mask,
                  at_min_mask, input ready);
  modport sink (input valid, mode, online_mask, freq_known_mask, at_max_mask,
                at_min_mask, output ready);
endinterface

@@ rtl/hpg_rsp_if.sv @@
// Result item channel of the hotplug governor.
interface hpg_rsp_if;
  import hpg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [CORE_W-1:0]       target_core;
  logic [IVL_W-1:0]        interval;
  logic signed [CNT_W-1:0] counter_value;

  modport source (output valid, action, target_core, interval, counter_value,
                  input ready);
  modport sink (input valid, action, target_core, interval, counter_value,
                output ready);
endinterface

@@ rtl/hpg_cfg_if.sv @@
// Register write channel of the hotplug governor.
interface hpg_cfg_if;
  import hpg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ rtl/core_hotplug_governor_unit.sv @@
// Core hotplug governor: top level with input stage, governor state and result register.
//
// One item per cycle is accepted while the receiver keeps up, and one result item is
// produced for each: the item is captured in an input register at the accepting edge,
// and from there the masks, thresholds and hysteresis counters are evaluated in one
// pass of logic that loads the result register and the governor state together once
// the result register is free or being read, so the result is registered on its way out.
// The next item sees the updated counters and interval. When the receiver holds off,
// the input register and the result register hold two items before the input stalls.
// Display-off and display-on items act whether or not the governor is enabled. Only
// cores 0..min(CORES,4)-1 take part. Registers may be written only while no item is
// in flight.
module core_hotplug_governor_unit
  import hpg_pkg::*;
#(
  parameter int CORES            = 4,
  parameter int DEFAULT_INTERVAL = 10,
  parameter int MAX_INTERVAL     = 1000
) (
  input  logic      clk,
  input  logic      rst,
  hpg_req_if.sink   req,
  hpg_rsp_if.source rsp,
  hpg_cfg_if.sink   cfg
);

  localparam int LIVE = (CORES < 4) ? CORES : 4;
  localparam logic [IVL_W-1:0] IVL_DEF = IVL_W'(DEFAULT_INTERVAL);
  localparam logic [IVL_W-1:0] IVL_MAX = IVL_W'(MAX_INTERVAL);

  cfg_t regs;
  dec_t dec;

  // input stage
  logic              s1_valid;
  logic [MODE_W-1:0] s1_mode;
  logic [MASK_W-1:0] s1_online, s1_known, s1_atmax, s1_atmin;
  logic              s1_adv;

  // governor state
  logic [CNT_SLOTS-1:0][CNT_W-1:0] counters;
  logic                            display_on, display_on_next;
  logic [IVL_W-1:0]                sample_interval, sample_interval_next;
  logic                            tick;

  // result register
  logic                    o_valid;
  logic [1:0]              o_action;
  logic [CORE_W-1:0]       o_core;
  logic [IVL_W-1:0]        o_interval;
  logic signed [CNT_W-1:0] o_count;

  hpg_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign tick = (s1_mode == MODE_TICK) && regs.enable;

  hpg_select #(.LIVE(LIVE)) u_sel (
    .tick     (tick),
    .online   (s1_online),
    .known    (s1_known),
    .atmax    (s1_atmax),
    .atmin    (s1_atmin),
    .regs     (regs),
    .counters (counters),
    .dec      (dec)
  );

  assign s1_adv    = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_comb begin
    display_on_next      = display_on;
    sample_interval_next = sample_interval;
    case (s1_mode)
      MODE_DISP_OFF: display_on_next = 1'b0;
      MODE_DISP_ON: begin
        display_on_next      = 1'b1;
        sample_interval_next = IVL_DEF;
      end
      MODE_TICK: begin
        if (regs.enable && !display_on && sample_interval < IVL_MAX)
          sample_interval_next = sample_interval + 10'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      o_valid         <= 1'b0;
      counters        <= '0;
      display_on      <= 1'b1;
      sample_interval <= IVL_DEF;
    end else begin
      if (req.valid && req.ready) s1_valid <= 1'b1;
      else if (s1_adv)            s1_valid <= 1'b0;

      if (s1_adv)         o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;

      if (s1_adv) begin
        display_on      <= display_on_next;
        sample_interval <= sample_interval_next;
        if (dec.touch) counters[dec.core] <= dec.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode   <= req.mode;
      s1_online <= req.online_mask;
      s1_known  <= req.freq_known_mask;
      s1_atmax  <= req.at_max_mask;
      s1_atmin  <= req.at_min_mask;
    end
    if (s1_adv) begin
      o_action   <= dec.action;
      o_core     <= dec.core;
      o_interval <= sample_interval_next;
      o_count    <= dec.count;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.action        = o_action;
  assign rsp.target_core   = o_core;
  assign rsp.interval      = o_interval;
  assign rsp.counter_value = o_count;

  a_plug_value : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.action == ACT_UP |-> rsp.counter_value == PLUG_VALUE)
    else $error("plug result without plug counter value");

  a_action_core : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.action != ACT_NONE |-> rsp.target_core != '0)
    else $error("action on core 0");

  a_interval_range : assert property (@(posedge clk) disable iff (rst)
    sample_interval <= IVL_MAX || sample_interval == IVL_DEF)
    else $error("sampling interval out of range");

  a_display_on : assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_mode == MODE_DISP_ON |=> display_on && sample_interval == IVL_DEF)
    else $error("display-on item did not restore interval");

endmodule

@@ rtl/hpg_cfg_regs.sv @@
// Configuration register file: enable and plug/unplug thresholds.
module hpg_cfg_regs
  import hpg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  hpg_cfg_if.sink cfg,
  output cfg_t   regs
);

  logic [1:0] slot;

  assign cfg.ready = 1'b1;

  always_comb begin
    slot = 2'd0;
    case (cfg.idx)
      CFG_UP2, CFG_DOWN2: slot = 2'd1;
      CFG_UP3, CFG_DOWN3: slot = 2'd2;
      default:            slot = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable   <= 1'b1;
      regs.up_thr   <= UP_RESET;
      regs.down_thr <= DOWN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.idx) inside
        CFG_ENABLE:                  regs.enable <= cfg.data[0];
        CFG_UP1, CFG_UP2, CFG_UP3:   regs.up_thr[slot] <= cfg.data;
        CFG_DOWN1, CFG_DOWN2, CFG_DOWN3: regs.down_thr[slot] <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/hpg_select.sv @@
// Tick evaluation: core counts, candidate core and hysteresis counter update.
module hpg_select
  import hpg_pkg::*;
#(
  parameter int LIVE = 4
) (
  input  logic                                tick,   // enabled sample tick
  input  logic [MASK_W-1:0]                   online,
  input  logic [MASK_W-1:0]                   known,
  input  logic [MASK_W-1:0]                   atmax,
  input  logic [MASK_W-1:0]                   atmin,
  input  cfg_t                                regs,
  input  logic [CNT_SLOTS-1:0][CNT_W-1:0]     counters,
  output dec_t                                dec
);

  logic [2:0]              n_on, n_max, n_min;
  logic                    plug_hit, unplug_hit;
  logic [CORE_W-1:0]       plug_core, unplug_core;
  logic                    go_plug, go_unplug;
  logic [CORE_W-1:0]       core;
  logic [1:0]              thr_sel;
  logic signed [CNT_W-1:0] cur, up_x, down_x;

  always_comb begin
    n_on  = '0;
    n_max = '0;
    n_min = '0;
    for (int i = 0; i < LIVE; i++) begin
      if (online[i]) n_on = n_on + 3'd1;
      // the top live core never counts toward max/min
      if (i < LIVE - 1 && known[i]) begin
        if (atmax[i]) n_max = n_max + 3'd1;
        else if (atmin[i]) n_min = n_min + 3'd1;
      end
    end
  end

  // lowest offline core above 0, highest online core above 0
  always_comb begin
    plug_hit    = 1'b0;
    plug_core   = '0;
    unplug_hit  = 1'b0;
    unplug_core = '0;
    for (int i = LIVE - 1; i > 0; i--) begin
      if (!online[i]) begin
        plug_hit  = 1'b1;
        plug_core = CORE_W'(i);
      end
    end
    for (int i = 1; i < LIVE; i++) begin
      if (online[i]) begin
        unplug_hit  = 1'b1;
        unplug_core = CORE_W'(i);
      end
    end
  end

  assign go_plug   = tick && (n_max == n_on) && plug_hit;
  assign go_unplug = tick && (n_max != n_on) && (n_min != 3'd0) && unplug_hit;
  assign core      = go_plug ? plug_core : unplug_core;
  assign thr_sel   = core - 2'd1;
  assign cur       = signed'(counters[core]);
  assign up_x      = CNT_W'(signed'(regs.up_thr[thr_sel]));
  assign down_x    = signed'({2'b00, regs.down_thr[thr_sel]});

  always_comb begin
    dec = '0;
    if (go_plug) begin
      dec.touch = 1'b1;
      dec.core  = core;
      if (cur < up_x) begin
        dec.count  = PLUG_VALUE;
        dec.action = ACT_UP;
      end else if (cur != CNT_MIN) begin
        dec.count = cur - 10'sd1;
      end else begin
        dec.count = cur;
      end
    end else if (go_unplug) begin
      dec.touch = 1'b1;
      dec.core  = core;
      if (cur > down_x) begin
        dec.count  = '0;
        dec.action = ACT_DOWN;
      end else if (cur != CNT_MAX) begin
        dec.count = cur + 10'sd1;
      end else begin
        dec.count = cur;
      end
    end
  end

endmodule
